[rtl/core/osw_pkg.sv]
// Shared types and constants for the override supervisor watchdog.
package osw_pkg;

    // Item operation codes; code seven is unused and only reports status.
    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_HEARTBEAT = 3'd1,
        MODE_DIGEST    = 3'd2,
        MODE_BUTTON    = 3'd3,
        MODE_CLEAR     = 3'd4,
        MODE_ASSERT    = 3'd5,
        MODE_READ      = 3'd6
    } t_mode;

    // Override reason codes; heartbeat and attestation reasons have a dedicated annunciator indication.
    localparam logic [7:0] RSN_NONE      = 8'd0;
    localparam logic [7:0] RSN_HEARTBEAT = 8'd1;
    localparam logic [7:0] RSN_ATTEST    = 8'd2;
    localparam logic [7:0] RSN_BUTTON    = 8'd3;

    // Annunciator codes.
    localparam logic [1:0] ANNC_IDLE    = 2'd0;
    localparam logic [1:0] ANNC_HB_LOST = 2'd1;
    localparam logic [1:0] ANNC_CHAIN   = 2'd2;
    localparam logic [1:0] ANNC_OTHER   = 2'd3;

    // Digest sequence verdicts.
    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_GAP    = 2'd1;
    localparam logic [1:0] VERDICT_REPLAY = 2'd2;

    // Heartbeat timeout after reset, in milliseconds.
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    // Per-item status produced by the decision logic.
    typedef struct packed {
        logic       accepted;
        logic [1:0] verdict;
        logic [1:0] annunciator;
        logic       kill_line;
        logic       override_active;
        logic [7:0] override_code;
        logic       stale;
        logic       read_hit;
    } t_status;

endpackage

[rtl/core/osw_if.sv]
// Valid/ready channel interfaces for supervisor items and results.
interface osw_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [63:0] seq_ref;
    logic [63:0] digest;
    logic        pressed;
    logic [7:0]  reason_in;
    logic [7:0]  index;

    modport source (
        output valid, mode, now_ms, seq_ref, digest, pressed, reason_in, index,
        input  ready
    );
    modport sink (
        input  valid, mode, now_ms, seq_ref, digest, pressed, reason_in, index,
        output ready
    );
endinterface

interface osw_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  verdict;
    logic [1:0]  annunciator;
    logic        kill_line;
    logic        override_active;
    logic [7:0]  override_code;
    logic [63:0] retained_ref;
    logic [63:0] retained_digest;
    logic        stale;

    modport source (
        output valid, accepted, verdict, annunciator, kill_line, override_active,
               override_code, retained_ref, retained_digest, stale,
        input  ready
    );
    modport sink (
        input  valid, accepted, verdict, annunciator, kill_line, override_active,
               override_code, retained_ref, retained_digest, stale,
        output ready
    );
endinterface

[rtl/core/osw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module osw_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/osw_ctrl.sv]
// Supervisor state, override latch and per-item decision logic.
module osw_ctrl #(
    parameter int RING_DEPTH  = 16,
    parameter int DIGEST_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_take,
    input  logic [2:0]                     i_mode,
    input  logic [31:0]                    i_now_ms,
    input  logic [63:0]                    i_seq_ref,
    input  logic [63:0]                    i_digest,
    input  logic                           i_pressed,
    input  logic [7:0]                     i_reason_in,
    input  logic [7:0]                     i_index,
    output osw_pkg::t_status               o_status,
    output logic                           o_ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]  o_ram_waddr,
    output logic [64+DIGEST_BITS-1:0]      o_ram_wdata,
    output logic [$clog2(RING_DEPTH)-1:0]  o_ram_raddr
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);

    logic [31:0] r_timeout, n_timeout;
    logic        r_latched, n_latched;
    logic [7:0]  r_reason, n_reason;
    logic        r_seen, n_seen;
    logic [31:0] r_last, n_last;
    logic        r_button, n_button;
    logic        r_chain, n_chain;
    logic [63:0] r_expected, n_expected;
    logic [63:0] r_reported, n_reported;
    logic [AW-1:0] r_wpos, n_wpos;
    logic [FW-1:0] r_fill, n_fill;

    logic          stale_before;
    logic          ring_full;
    logic [AW-1:0] base;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot;
    logic          idx_in_range;

    // Read slot: oldest entry plus index, wrapped once at the ring depth.
    always_comb begin
        ring_full    = (r_fill == FW'(RING_DEPTH));
        base         = ring_full ? r_wpos : '0;
        slot_sum     = {1'b0, base} + {1'b0, i_index[AW-1:0]};
        if (slot_sum >= (AW+1)'(RING_DEPTH)) begin
            slot = AW'(slot_sum - (AW+1)'(RING_DEPTH));
        end else begin
            slot = slot_sum[AW-1:0];
        end
        idx_in_range = (9'(i_index) < 9'(r_fill));
    end

    assign stale_before = ((i_now_ms - r_last) > r_timeout);
    assign o_ram_raddr  = slot;
    assign o_ram_waddr  = r_wpos;
    assign o_ram_wdata  = {i_seq_ref, i_digest[DIGEST_BITS-1:0]};

    // Next state and item status.
    always_comb begin
        n_timeout  = i_cfg_we ? i_cfg_data : r_timeout;
        n_latched  = r_latched;
        n_reason   = r_reason;
        n_seen     = r_seen;
        n_last     = r_last;
        n_button   = r_button;
        n_chain    = r_chain;
        n_expected = r_expected;
        n_reported = r_reported;
        n_wpos     = r_wpos;
        n_fill     = r_fill;
        o_ram_we   = 1'b0;
        o_status   = '0;

        unique case (i_mode)
            osw_pkg::MODE_TICK: begin
                if (stale_before && !r_latched) begin
                    n_latched         = 1'b1;
                    n_reason          = osw_pkg::RSN_HEARTBEAT;
                    o_status.accepted = 1'b1;
                end
            end
            osw_pkg::MODE_HEARTBEAT: begin
                n_seen     = 1'b1;
                n_last     = i_now_ms;
                n_reported = i_seq_ref;
            end
            osw_pkg::MODE_DIGEST: begin
                if (i_seq_ref <= r_expected) begin
                    o_status.verdict = osw_pkg::VERDICT_REPLAY;
                end else if ((i_seq_ref - r_expected) > 64'd1) begin
                    o_status.verdict = osw_pkg::VERDICT_GAP;
                end
                if (o_status.verdict == osw_pkg::VERDICT_OK) begin
                    o_ram_we   = i_take;
                    n_wpos     = (r_wpos == AW'(RING_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                    n_fill     = ring_full ? r_fill : r_fill + 1'b1;
                    n_expected = i_seq_ref;
                end else begin
                    n_chain = 1'b1;
                    if (!r_latched) begin
                        n_latched         = 1'b1;
                        n_reason          = osw_pkg::RSN_ATTEST;
                        o_status.accepted = 1'b1;
                    end
                end
            end
            osw_pkg::MODE_BUTTON: begin
                n_button = i_pressed;
                if (i_pressed && !r_button && !r_latched) begin
                    n_latched         = 1'b1;
                    n_reason          = osw_pkg::RSN_BUTTON;
                    o_status.accepted = 1'b1;
                end
            end
            osw_pkg::MODE_CLEAR: begin
                if (!r_latched) begin
                    o_status.accepted = 1'b1;
                end else if (!r_button && r_seen && !stale_before) begin
                    // Resynchronize the chain to the last reported reference.
                    if (r_chain && (r_reported > r_expected)) begin
                        n_expected = r_reported;
                    end
                    n_latched         = 1'b0;
                    n_reason          = osw_pkg::RSN_NONE;
                    n_chain           = 1'b0;
                    o_status.accepted = 1'b1;
                end
            end
            osw_pkg::MODE_ASSERT: begin
                if (!r_latched) begin
                    n_latched         = 1'b1;
                    n_reason          = i_reason_in;
                    o_status.accepted = 1'b1;
                end
            end
            osw_pkg::MODE_READ: begin
                o_status.read_hit = idx_in_range;
                o_status.accepted = idx_in_range;
            end
            default: begin
            end
        endcase

        // Status after the item's update.
        o_status.override_active = n_latched;
        o_status.override_code   = n_latched ? n_reason : osw_pkg::RSN_NONE;
        o_status.kill_line       = n_latched || !n_seen;
        o_status.stale           = ((i_now_ms - n_last) > r_timeout);
        if (!n_latched) begin
            o_status.annunciator = osw_pkg::ANNC_IDLE;
        end else if (n_reason == osw_pkg::RSN_HEARTBEAT) begin
            o_status.annunciator = osw_pkg::ANNC_HB_LOST;
        end else if (n_reason == osw_pkg::RSN_ATTEST) begin
            o_status.annunciator = osw_pkg::ANNC_CHAIN;
        end else begin
            o_status.annunciator = osw_pkg::ANNC_OTHER;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= osw_pkg::TIMEOUT_RESET;
        end else begin
            r_timeout <= n_timeout;
        end
    end

    // Supervisor state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched  <= 1'b0;
            r_reason   <= osw_pkg::RSN_NONE;
            r_seen     <= 1'b0;
            r_last     <= '0;
            r_button   <= 1'b0;
            r_chain    <= 1'b0;
            r_expected <= '0;
            r_reported <= '0;
            r_wpos     <= '0;
            r_fill     <= '0;
        end else if (i_take) begin
            r_latched  <= n_latched;
            r_reason   <= n_reason;
            r_seen     <= n_seen;
            r_last     <= n_last;
            r_button   <= n_button;
            r_chain    <= n_chain;
            r_expected <= n_expected;
            r_reported <= n_reported;
            r_wpos     <= n_wpos;
            r_fill     <= n_fill;
        end
    end

endmodule

[rtl/core/override_supervisor_watchdog.sv]
// Override supervisor watchdog: top level with result pipeline and retained ring.
// Path: each item's status is registered in stage one and then in the output register, where
// it is offered. Throughput: one item per cycle while the output is not stalled; the ring
// RAM's registered read sets the extra stage.
// A result register plus an output register let one more item enter while a result waits.
// Reset (synchronous, active low) clears the latch, heartbeat and chain state and the
// ring pointers; ring contents are not cleared, since no unwritten entry is ever read.
module override_supervisor_watchdog #(
    parameter int RING_DEPTH  = 16,
    parameter int DIGEST_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    osw_in_if.sink      i_item,
    osw_out_if.source   o_res
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int RW = 64 + DIGEST_BITS;

    logic             take;
    logic             s1_move;
    osw_pkg::t_status status;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [RW-1:0]    ram_wdata;
    logic [RW-1:0]    ram_rdata;

    logic             r_s1_valid;
    osw_pkg::t_status r_s1_status;
    logic             r_o_valid;
    osw_pkg::t_status r_o_status;
    logic [63:0]      r_o_ref;
    logic [63:0]      r_o_digest;

    // Handshake: stage one drains into the output register when that is free or leaving.
    assign s1_move      = r_s1_valid && (!r_o_valid || o_res.ready);
    assign i_item.ready = !r_s1_valid || s1_move;
    assign take         = i_item.valid && i_item.ready;

    osw_ctrl #(
        .RING_DEPTH  (RING_DEPTH),
        .DIGEST_BITS (DIGEST_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_mode      (i_item.mode),
        .i_now_ms    (i_item.now_ms),
        .i_seq_ref   (i_item.seq_ref),
        .i_digest    (i_item.digest),
        .i_pressed   (i_item.pressed),
        .i_reason_in (i_item.reason_in),
        .i_index     (i_item.index),
        .o_status    (status),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr)
    );

    osw_ram #(
        .WIDTH (RW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (take),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Stage one: item status, alongside the ring read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_status <= status;
        end
    end

    // Output register; retained fields are zero unless the read hit a valid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_status <= r_s1_status;
            r_o_ref    <= r_s1_status.read_hit ? ram_rdata[RW-1:DIGEST_BITS] : '0;
            r_o_digest <= r_s1_status.read_hit ? 64'(ram_rdata[DIGEST_BITS-1:0]) : '0;
        end
    end

    assign o_res.valid           = r_o_valid;
    assign o_res.accepted        = r_o_status.accepted;
    assign o_res.verdict         = r_o_status.verdict;
    assign o_res.annunciator     = r_o_status.annunciator;
    assign o_res.kill_line       = r_o_status.kill_line;
    assign o_res.override_active = r_o_status.override_active;
    assign o_res.override_code   = r_o_status.override_code;
    assign o_res.stale           = r_o_status.stale;
    assign o_res.retained_ref    = r_o_ref;
    assign o_res.retained_digest = r_o_digest;

    // A result without a latched override shows the watching state only.
    a_watching_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_status.override_active) |->
        (r_o_status.override_code == osw_pkg::RSN_NONE &&
         r_o_status.annunciator == osw_pkg::ANNC_IDLE))
        else $error("override code or annunciator set while watching");

    // Any digest fault leaves the override latched.
    a_fault_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status.verdict != osw_pkg::VERDICT_OK) |->
        (r_o_status.override_active && r_o_status.kill_line))
        else $error("digest fault reported without a latched override");

    // With both stages full and the output stalled, no item may enter.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !o_res.ready) |-> !i_item.ready)
        else $error("input ready while the result pipeline is full");

endmodule
